/* rtl/rau_pkg.sv */
package rau_pkg;

    localparam int MagBits = 64;

    typedef enum logic [2:0] {
        OP_REDUCE = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_LESS   = 3'd5,
        OP_EQUAL  = 3'd6,
        OP_NONE   = 3'd7
    } rau_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_CHECK,
        ST_GCD_PAIR,
        ST_GCD_U,
        ST_GCD_V,
        ST_GCD_SUB,
        ST_DIV,
        ST_DONE
    } rau_state_t;

    // Signed-magnitude value
    typedef struct packed {
        logic               neg;
        logic [MagBits-1:0] mag;
    } rau_sm_t;

endpackage

/* rtl/rau_divider.sv */
// Restoring divider, one quotient bit per cycle; exact division only is asked for
module rau_divider
    import rau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MagBits-1:0] dividend,
    input  logic [MagBits-1:0] divisor,
    output logic               busy,
    output logic [MagBits-1:0] quotient
);

    localparam int CntBits = $clog2(MagBits + 1);

    logic [MagBits-1:0] rem_reg;
    logic [MagBits-1:0] quo_reg;
    logic [MagBits-1:0] dsr_reg;
    logic [CntBits-1:0] cnt_reg;
    logic               busy_reg;
    logic [MagBits:0]   trial;

    assign trial = {rem_reg, quo_reg[MagBits-1]} - {1'b0, dsr_reg};

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CntBits'(MagBits);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CntBits'(1));
        end
    end

    // Shift and subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[MagBits])
                rem_reg <= trial[MagBits-1:0];
            else
                rem_reg <= {rem_reg[MagBits-2:0], quo_reg[MagBits-1]};
            quo_reg <= {quo_reg[MagBits-2:0], ~trial[MagBits]};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/rational_arithmetic_unit_core.sv */
// Rational arithmetic unit. One request at a time: s_tready is high only when idle
// and the output register is empty. A request runs through one 32x32 multiplier
// (up to four products, one a cycle); a fraction result then goes through a 64-bit
// binary GCD loop, each step of which either removes a factor of two or does one
// subtraction. Two restoring divisions then run on one shared divider. Comparisons
// finish after the multiplier, and a zero numerator or denominator skips the GCD
// loop and the divisions.
module rational_arithmetic_unit_core
    import rau_pkg::*;
#(
    parameter int OPERAND_BITS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // req_type[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99], zero fill
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_num[63:0], res_den[126:64], is_less[127], is_equal[128], zero_den_error[129]
    output logic [135:0] m_tdata
);

    rau_state_t state_reg, state_next;

    rau_op_t       op_reg;
    rau_sm_t       an_reg, ad_reg, bn_reg, bd_reg;
    rau_sm_t       p0_reg, p1_reg, num_reg, den_reg;
    logic [1:0]    mstep_reg;
    logic [MagBits-1:0] u_reg, v_reg, g_reg;
    logic [6:0]    shift_reg;
    logic          dphase_reg;
    logic          div_kick_reg;
    logic [MagBits-1:0] qn_reg;
    logic          out_valid_reg;
    logic [135:0]  out_data_reg;

    // Sign-extend an operand from OPERAND_BITS and split into sign and magnitude
    function automatic rau_sm_t to_sm(input logic [31:0] raw);
        logic [31:0] ext;
        logic [31:0] m;
        rau_sm_t r;
        ext = 32'($signed(raw << (32 - OPERAND_BITS)) >>> (32 - OPERAND_BITS));
        m = ext[31] ? (~ext + 32'd1) : ext;
        r.neg = ext[31];
        r.mag = {32'd0, m};
        return r;
    endfunction

    // Shared multiplier
    rau_sm_t mul_x, mul_y, mul_p;
    always_comb
    begin
        mul_x = an_reg;
        mul_y = bd_reg;
        unique case (mstep_reg)
            2'd0: begin mul_x = an_reg; mul_y = bd_reg; end
            2'd1: begin mul_x = bn_reg; mul_y = ad_reg; end
            2'd2: begin mul_x = an_reg; mul_y = bn_reg; end
            default: begin mul_x = ad_reg; mul_y = bd_reg; end
        endcase
        mul_p.mag = {32'd0, mul_x.mag[31:0]} * {32'd0, mul_y.mag[31:0]};
        mul_p.neg = mul_x.neg ^ mul_y.neg;
        if (mul_p.mag == '0)
            mul_p.neg = 1'b0;
    end

    // Signed-magnitude sum of the two products, second optionally negated
    rau_sm_t sum_r;
    logic    yneg;
    always_comb
    begin
        yneg = p1_reg.neg ^ (op_reg == OP_SUB);
        if (p0_reg.neg == yneg)
            sum_r = '{neg: p0_reg.neg, mag: p0_reg.mag + p1_reg.mag};
        else if (p0_reg.mag >= p1_reg.mag)
            sum_r = '{neg: p0_reg.neg, mag: p0_reg.mag - p1_reg.mag};
        else
            sum_r = '{neg: yneg, mag: p1_reg.mag - p0_reg.mag};
        if (sum_r.mag == '0)
            sum_r.neg = 1'b0;
    end

    // Divider
    logic               div_start, div_busy;
    logic [MagBits-1:0] div_q, div_dividend;
    assign div_dividend = dphase_reg ? den_reg.mag : num_reg.mag;

    rau_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (g_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    logic in_fire, out_fire;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                    state_next = ST_MUL;
            ST_MUL:
                priority if (op_reg == OP_REDUCE || op_reg == OP_EQUAL || op_reg == OP_NONE)
                    state_next = (op_reg == OP_REDUCE) ? ST_CHECK : ST_DONE;
                else if (op_reg == OP_LESS && mstep_reg == 2'd1)
                    state_next = ST_DONE;
                else if (mstep_reg == 2'd3)
                    state_next = ST_SUM;
            ST_SUM:        state_next = ST_CHECK;
            ST_CHECK:
                if (den_reg.mag == '0 || num_reg.mag == '0)
                    state_next = ST_DONE;
                else
                    state_next = ST_GCD_PAIR;
            ST_GCD_PAIR:
                if (u_reg[0] || v_reg[0])
                    state_next = ST_GCD_U;
            ST_GCD_U:
                if (u_reg[0])
                    state_next = ST_GCD_V;
            ST_GCD_V:
                if (v_reg == '0)
                    state_next = ST_DIV;
                else if (v_reg[0])
                    state_next = ST_GCD_SUB;
            ST_GCD_SUB:    state_next = ST_GCD_V;
            ST_DIV:
                if (div_kick_reg && !div_busy && dphase_reg)
                    state_next = ST_DONE;
            ST_DONE:
                if (!out_valid_reg)
                    state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Launch a division whenever none is in flight in the divide state
    always_comb
    begin
        div_start = (state_reg == ST_DIV) && !div_kick_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mstep_reg     <= '0;
            dphase_reg    <= 1'b0;
            div_kick_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_fire)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (in_fire)
                    begin
                        mstep_reg    <= '0;
                        dphase_reg   <= 1'b0;
                        div_kick_reg <= 1'b0;
                    end
                ST_MUL:
                    mstep_reg <= mstep_reg + 2'd1;
                ST_DIV:
                    if (!div_kick_reg)
                        div_kick_reg <= 1'b1;
                    else if (!div_busy && !dphase_reg)
                    begin
                        dphase_reg   <= 1'b1;
                        div_kick_reg <= 1'b0;
                    end
                ST_DONE:
                    if (!out_valid_reg)
                        out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    op_reg  <= rau_op_t'(s_tdata[2:0]);
                    an_reg  <= to_sm(s_tdata[34:3]);
                    ad_reg  <= to_sm(s_tdata[66:35]);
                    bn_reg  <= to_sm(s_tdata[98:67]);
                    bd_reg  <= to_sm(s_tdata[130:99]);
                end
            ST_MUL:
            begin
                if (op_reg == OP_REDUCE)
                begin
                    num_reg <= an_reg;
                    den_reg <= ad_reg;
                end
                unique case (mstep_reg)
                    2'd0: p0_reg <= mul_p;
                    2'd1:
                    begin
                        p1_reg <= mul_p;
                        if (op_reg == OP_DIV)
                            den_reg <= mul_p;
                    end
                    2'd2:
                        if (op_reg == OP_MUL)
                            num_reg <= mul_p;
                    default:
                        if (op_reg != OP_DIV)
                            den_reg <= mul_p;
                endcase
            end
            ST_SUM:
                if (op_reg == OP_ADD || op_reg == OP_SUB)
                    num_reg <= sum_r;
                else if (op_reg == OP_DIV)
                    num_reg <= p0_reg;
            ST_CHECK:
            begin
                u_reg     <= num_reg.mag;
                v_reg     <= den_reg.mag;
                shift_reg <= '0;
            end
            ST_GCD_PAIR:
                if (!(u_reg[0] || v_reg[0]))
                begin
                    u_reg     <= u_reg >> 1;
                    v_reg     <= v_reg >> 1;
                    shift_reg <= shift_reg + 7'd1;
                end
            ST_GCD_U:
                if (!u_reg[0])
                    u_reg <= u_reg >> 1;
            ST_GCD_V:
                if (v_reg == '0)
                    g_reg <= u_reg << shift_reg;
                else if (!v_reg[0])
                    v_reg <= v_reg >> 1;
            ST_GCD_SUB:
                if (u_reg > v_reg)
                begin
                    u_reg <= v_reg;
                    v_reg <= u_reg - v_reg;
                end
                else
                    v_reg <= v_reg - u_reg;
            ST_DIV:
                // Hold the numerator quotient before the divider is reused
                if (div_kick_reg && !div_busy && !dphase_reg)
                    qn_reg <= div_q;
            default: ;
        endcase
    end

    // Build the result word
    logic [135:0] res_w;
    logic [63:0]  rn;
    always_comb
    begin
        res_w = '0;
        rn    = (num_reg.neg ^ den_reg.neg) ? (64'd0 - qn_reg) : qn_reg;
        unique case (op_reg)
            OP_LESS:
                res_w[127] = (p0_reg.neg != p1_reg.neg) ? p0_reg.neg :
                             (p0_reg.neg ? (p0_reg.mag > p1_reg.mag)
                                         : (p0_reg.mag < p1_reg.mag));
            OP_EQUAL:
                res_w[128] = (an_reg == bn_reg) && (ad_reg == bd_reg);
            OP_NONE: ;
            default:
                priority if (den_reg.mag == '0)
                    res_w[129] = 1'b1;
                else if (num_reg.mag == '0)
                    res_w[64] = 1'b1;
                else
                begin
                    res_w[63:0]   = rn;
                    res_w[126:64] = div_q[62:0];
                end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && !out_valid_reg)
            out_data_reg <= res_w;
    end

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready) else $error("accepted twice");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !div_busy) else $error("divider busy in idle");

endmodule

/* verif/tb_top.sv */
module tb_top
    import rau_pkg::*;
();

    localparam int HoldOffCycles = 3000;
    localparam int StallLimit    = 20000;
    localparam int DrainCycles   = 400;

    typedef struct {
        logic signed [63:0] num;
        logic [62:0]        den;
        logic               less;
        logic               equal;
        logic               zero_den;
    } fraction_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;

    fraction_result_t pending_results[$];
    int               mismatches;
    int               req_idle_pct;
    int               resp_idle_pct;
    int               hold_off_left;
    int               quiet_cycles;

    rational_arithmetic_unit_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Euclid on magnitudes, both nonzero
    function automatic logic [63:0] common_divisor(logic [63:0] u, logic [63:0] v);
        logic [63:0] t;
        while (v != 0)
        begin
            t = u % v;
            u = v;
            v = t;
        end
        return u;
    endfunction

    // Work out the reduced fraction or flag for one request
    function automatic fraction_result_t predict_fraction(rau_op_t op,
            logic signed [31:0] an, logic signed [31:0] ad,
            logic signed [31:0] bn, logic signed [31:0] bd);
        fraction_result_t r;
        logic signed [63:0] num;
        logic signed [63:0] den;
        logic [63:0]        nmag;
        logic [63:0]        dmag;
        logic [63:0]        g;
        logic               neg;
        r = '{num: '0, den: '0, less: 1'b0, equal: 1'b0, zero_den: 1'b0};
        case (op)
            OP_REDUCE:
            begin
                num = an;
                den = ad;
            end
            OP_ADD:
            begin
                num = 64'(an) * 64'(bd) + 64'(bn) * 64'(ad);
                den = 64'(ad) * 64'(bd);
            end
            OP_SUB:
            begin
                num = 64'(an) * 64'(bd) - 64'(bn) * 64'(ad);
                den = 64'(ad) * 64'(bd);
            end
            OP_MUL:
            begin
                num = 64'(an) * 64'(bn);
                den = 64'(ad) * 64'(bd);
            end
            OP_DIV:
            begin
                num = 64'(an) * 64'(bd);
                den = 64'(ad) * 64'(bn);
            end
            OP_LESS:
            begin
                r.less = (64'(an) * 64'(bd)) < (64'(ad) * 64'(bn));
                return r;
            end
            OP_EQUAL:
            begin
                r.equal = (an == bn) && (ad == bd);
                return r;
            end
            default:
                return r;
        endcase
        if (den == 0)
        begin
            r.zero_den = 1'b1;
            return r;
        end
        if (num == 0)
        begin
            r.den = 63'd1;
            return r;
        end
        neg  = (num < 0) != (den < 0);
        nmag = (num < 0) ? -num : num;
        dmag = (den < 0) ? -den : den;
        g    = common_divisor(nmag, dmag);
        nmag = nmag / g;
        dmag = dmag / g;
        r.num = neg ? -nmag : nmag;
        r.den = dmag[62:0];
        return r;
    endfunction

    // Offer one request and record its expected result on transfer
    task automatic send_request(rau_op_t op, logic [31:0] an, logic [31:0] ad,
            logic [31:0] bn, logic [31:0] bd);
        while ($urandom_range(99) < req_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, bd, bn, ad, an, op};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_fraction(op, an, ad, bn, bd));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Operand value: mostly small so fractions reduce, some full range
    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = 32'($urandom_range(40)) - 32'd20;
            1: v = 32'($urandom_range(2000)) - 32'd1000;
            2: v = 32'($urandom_range(200000)) - 32'd100000;
            default: v = $urandom;
        endcase
        if (v == 32'h8000_0000)
            v = 32'h8000_0001;
        return v;
    endfunction

    function automatic logic [31:0] pick_denominator();
        case ($urandom_range(19))
            0: return 32'd0;
            1, 2: return pick_operand();
            default: return (pick_operand() & 32'h7fff_ffff) | 32'd1;
        endcase
    endfunction

    task automatic send_random(int count);
        rau_op_t     op;
        logic [31:0] an;
        logic [31:0] bn;
        for (int i = 0; i < count; i++)
        begin
            op = rau_op_t'(($urandom_range(49) == 0) ? 7 : $urandom_range(6));
            an = pick_operand();
            bn = pick_operand();
            send_request(op, an, pick_denominator(), bn, pick_denominator());
        end
    endtask

    task automatic test_directed();
        send_request(OP_REDUCE, 32'd6, -32'sd4, 32'd0, 32'd1);
        send_request(OP_REDUCE, 32'd0, 32'd7, 32'd0, 32'd1);
        send_request(OP_REDUCE, 32'd5, 32'd0, 32'd0, 32'd1);
        send_request(OP_REDUCE, 32'd0, 32'd0, 32'd0, 32'd0);
        send_request(OP_REDUCE, 32'h7fff_ffff, 32'h8000_0001, 32'd0, 32'd1);
        send_request(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_request(OP_ADD, 32'd1, 32'd2, -32'sd1, 32'd2);
        send_request(OP_ADD, 32'h8000_0001, 32'h7fff_ffff, 32'h8000_0001, 32'h7fff_fffe);
        send_request(OP_SUB, 32'd3, 32'd4, 32'd5, 32'd6);
        send_request(OP_SUB, 32'h7fff_ffff, 32'h7fff_fffe, 32'h8000_0001, 32'h7fff_ffff);
        send_request(OP_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
        send_request(OP_MUL, 32'h8000_0001, 32'h7fff_ffff, 32'h8000_0001, 32'd3);
        send_request(OP_MUL, 32'd4, 32'd0, 32'd2, 32'd5);
        send_request(OP_DIV, 32'd2, 32'd3, 32'd4, 32'd9);
        send_request(OP_DIV, 32'd2, 32'd3, 32'd0, 32'd9);
        send_request(OP_DIV, 32'd0, 32'd3, 32'd0, 32'd9);
        send_request(OP_LESS, 32'd1, 32'd3, 32'd1, 32'd2);
        send_request(OP_LESS, 32'd1, 32'd2, 32'd1, 32'd3);
        send_request(OP_LESS, 32'h8000_0001, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0001);
        send_request(OP_EQUAL, 32'd2, 32'd4, 32'd2, 32'd4);
        send_request(OP_EQUAL, 32'd1, 32'd2, 32'd2, 32'd4);
        send_request(OP_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    endtask

    task automatic test_random_traffic();
        req_idle_pct  = 33;
        resp_idle_pct = 82;
        send_random(220);
        req_idle_pct  = 82;
        resp_idle_pct = 33;
        send_random(210);
        req_idle_pct  = 0;
        resp_idle_pct = 0;
        send_random(210);
    endtask

    // Stall the output long enough for the block to refuse new requests
    task automatic test_backpressure();
        wait_drained();
        hold_off_left = HoldOffCycles;
        send_random(6);
        wait_drained();
    endtask

    // Result receiver with random stalls and an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_off_left > 0)
        begin
            hold_off_left <= hold_off_left - 1;
            m_tready      <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= resp_idle_pct);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        fraction_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (m_tdata[63:0] !== e.num)
                begin
                    $error("res_num expected %0d got %0d", e.num, $signed(m_tdata[63:0]));
                    mismatches++;
                end
                if (m_tdata[126:64] !== e.den)
                begin
                    $error("res_den expected %0d got %0d", e.den, m_tdata[126:64]);
                    mismatches++;
                end
                if (m_tdata[127] !== e.less)
                begin
                    $error("is_less expected %0b got %0b", e.less, m_tdata[127]);
                    mismatches++;
                end
                if (m_tdata[128] !== e.equal)
                begin
                    $error("is_equal expected %0b got %0b", e.equal, m_tdata[128]);
                    mismatches++;
                end
                if (m_tdata[129] !== e.zero_den)
                begin
                    $error("zero_den_error expected %0b got %0b", e.zero_den, m_tdata[129]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= StallLimit)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        mismatches    = 0;
        req_idle_pct  = 0;
        resp_idle_pct = 0;
        hold_off_left = 0;
        quiet_cycles  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic();
        test_backpressure();

        wait_drained();
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/rau_pkg.sv
rtl/rau_divider.sv
rtl/rational_arithmetic_unit_core.sv
verif/tb_top.sv
